[src/joystick_axis_calibrated_scaler_macros.svh]
// Assertion helpers for the axis scaler.
`ifndef JOYSTICK_AXIS_CALIBRATED_SCALER_MACROS_SVH
`define JOYSTICK_AXIS_CALIBRATED_SCALER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define JACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define JACS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define JACS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[src/jacs_pkg.sv]
package jacs_pkg;

    localparam int CALC_W    = 16;
    localparam int QUOT_W    = 7;
    localparam int PROD_W    = 23;
    localparam int MAP_W     = 19;
    localparam int THR_W     = 18;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_POINT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_PLAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_AXIS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_IDLE  = 3'd6;

    localparam logic [1:0] MODE_SYM = 2'd0;
    localparam logic [1:0] MODE_POS = 2'd1;
    localparam logic [1:0] MODE_THR = 2'd2;
    localparam logic [1:0] MODE_HAT = 2'd3;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam logic [2:0] HAT_CENTER = 3'd4;

    localparam logic [QUOT_W-1:0] FULL_SCALE  = 7'd100;
    localparam logic [QUOT_W-1:0] DETENT_POS  = 7'd75;
    localparam logic [QUOT_W-1:0] DETENT_SPAN = 7'd25;

    localparam logic [CALC_W-1:0] TRACK_LOW_RESET  = 16'h7fff;
    localparam logic [CALC_W-1:0] TRACK_HIGH_RESET = 16'h0000;

    localparam logic [1:0]        RST_AXIS_MODE    = MODE_SYM;
    localparam logic [CALC_W-1:0] RST_RANGE_BASE   = 16'd0;
    localparam logic [CALC_W-1:0] RST_RANGE_TOP    = 16'hffff;
    localparam logic [CALC_W-1:0] RST_CENTER_POINT = 16'h8000;
    localparam logic [CALC_W-1:0] RST_DEAD_PLAY    = 16'd0;
    localparam logic              RST_INVERT_AXIS  = 1'b0;
    localparam logic [6:0]        RST_DETENT_IDLE  = 7'd10;

    typedef struct packed {
        logic              operation;
        logic [CALC_W-1:0] raw_count;
        logic              timed_out;
        logic              last_of_burst;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0] axis_value;
        logic [2:0]        hat_direction;
        logic              read_failed;
        logic [CALC_W-1:0] burst_minimum;
        logic [CALC_W-1:0] tracked_low;
        logic [CALC_W-1:0] tracked_high;
    } t_out_beat;

    typedef struct packed {
        logic [1:0]        axis_mode;
        logic [CALC_W-1:0] range_base;
        logic [CALC_W-1:0] range_top;
        logic [CALC_W-1:0] center_point;
        logic [CALC_W-1:0] dead_play;
        logic              invert_axis;
        logic [6:0]        detent_idle;
    } t_cfg;

    typedef struct packed {
        logic              start;
        logic [CALC_W-1:0] x;
        logic [CALC_W-1:0] den;
        logic [QUOT_W-1:0] k;
    } t_scale_req;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quot;
    } t_scale_rsp;

endpackage

[src/jacs_cfg.sv]
module jacs_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [jacs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [jacs_pkg::CALC_W-1:0]        i_cfg_data,
    output jacs_pkg::t_cfg                     o_cfg
);

    jacs_pkg::t_cfg r_cfg;
    jacs_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                jacs_pkg::CFG_AXIS_MODE:    n_cfg.axis_mode    = i_cfg_data[1:0];
                jacs_pkg::CFG_RANGE_BASE:   n_cfg.range_base   = i_cfg_data;
                jacs_pkg::CFG_RANGE_TOP:    n_cfg.range_top    = i_cfg_data;
                jacs_pkg::CFG_CENTER_POINT: n_cfg.center_point = i_cfg_data;
                jacs_pkg::CFG_DEAD_PLAY:    n_cfg.dead_play    = i_cfg_data;
                jacs_pkg::CFG_INVERT_AXIS:  n_cfg.invert_axis  = i_cfg_data[0];
                jacs_pkg::CFG_DETENT_IDLE:  n_cfg.detent_idle  = i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.axis_mode    <= jacs_pkg::RST_AXIS_MODE;
            r_cfg.range_base   <= jacs_pkg::RST_RANGE_BASE;
            r_cfg.range_top    <= jacs_pkg::RST_RANGE_TOP;
            r_cfg.center_point <= jacs_pkg::RST_CENTER_POINT;
            r_cfg.dead_play    <= jacs_pkg::RST_DEAD_PLAY;
            r_cfg.invert_axis  <= jacs_pkg::RST_INVERT_AXIS;
            r_cfg.detent_idle  <= jacs_pkg::RST_DETENT_IDLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[src/jacs_scale.sv]
// k * x / den, bit-serial: one multiplier bit per cycle, then one quotient bit per cycle.
module jacs_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  jacs_pkg::t_scale_req i_req,
    output jacs_pkg::t_scale_rsp o_rsp
);

    localparam int PW        = jacs_pkg::PROD_W;
    localparam int QW        = jacs_pkg::QUOT_W;
    localparam int DIV_SHIFT = QW - 1;
    localparam logic [2:0] LAST_STEP = 3'(QW - 1);

    logic          r_busy, n_busy;
    logic          r_div, n_div;
    logic          r_done, n_done;
    logic [2:0]    r_cnt, n_cnt;
    logic [PW-1:0] r_acc, n_acc;
    logic [PW-1:0] r_xs, n_xs;
    logic [PW-1:0] r_dsh, n_dsh;
    logic [QW-1:0] r_k, n_k;
    logic [QW-1:0] r_quot, n_quot;

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

    always_comb begin
        n_busy = r_busy;
        n_div  = r_div;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_xs   = r_xs;
        n_dsh  = r_dsh;
        n_k    = r_k;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_div  = 1'b0;
            n_cnt  = '0;
            n_acc  = '0;
            n_xs   = PW'(i_req.x);
            n_dsh  = PW'(i_req.den) << DIV_SHIFT;
            n_k    = i_req.k;
            n_quot = '0;
        end else if (r_busy) begin
            if (!r_div) begin
                if (r_k[0]) begin
                    n_acc = r_acc + r_xs;
                end
                n_xs = r_xs << 1;
                n_k  = r_k >> 1;
                if (r_cnt == LAST_STEP) begin
                    n_cnt = '0;
                    n_div = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end else begin
                if (r_acc >= r_dsh) begin
                    n_acc  = r_acc - r_dsh;
                    n_quot = {r_quot[QW-2:0], 1'b1};
                end else begin
                    n_quot = {r_quot[QW-2:0], 1'b0};
                end
                n_dsh = r_dsh >> 1;
                if (r_cnt == LAST_STEP) begin
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_div  <= n_div;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_xs   <= n_xs;
            r_dsh  <= n_dsh;
            r_k    <= n_k;
            r_quot <= n_quot;
        end
    end

endmodule

[src/joystick_axis_calibrated_scaler.sv]
// Samples that do not end a burst and tracker clears are taken in the idle state.
// A burst's last sample on a failed read goes straight to S_EMIT; a saturated or
// dead-zone value passes S_MAP and S_POST; a scaled value also waits in S_WAIT1 for
// one bit-serial scale pass, and throttle mode may wait in S_WAIT2 for a second.
// The next item is accepted in the cycle after the result enters the output register.
// Synchronous active-low reset restores state, output valid, trackers, burst minimum and configuration.
`include "joystick_axis_calibrated_scaler_macros.svh"

module joystick_axis_calibrated_scaler #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  jacs_pkg::t_in_beat              i_in_beat,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output jacs_pkg::t_out_beat             o_out_beat,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [jacs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [jacs_pkg::CALC_W-1:0]     i_cfg_data
);

    localparam int CW = jacs_pkg::CALC_W;
    localparam int QW = jacs_pkg::QUOT_W;
    localparam int MW = jacs_pkg::MAP_W;
    localparam int TW = jacs_pkg::THR_W;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [7:0] HAT_BIAS = 8'(jacs_pkg::FULL_SCALE / 8);
    localparam logic [7:0] HAT_Q1   = 8'(jacs_pkg::FULL_SCALE / 4);
    localparam logic [7:0] HAT_Q2   = 8'(2 * (jacs_pkg::FULL_SCALE / 4));
    localparam logic [7:0] HAT_Q3   = 8'(3 * (jacs_pkg::FULL_SCALE / 4));
    localparam logic [7:0] HAT_Q4   = 8'(4 * (jacs_pkg::FULL_SCALE / 4));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAP   = 3'd1;
    localparam logic [2:0] S_WAIT1 = 3'd2;
    localparam logic [2:0] S_POST  = 3'd3;
    localparam logic [2:0] S_WAIT2 = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    jacs_pkg::t_cfg       cfg;
    jacs_pkg::t_scale_req scale_req;
    jacs_pkg::t_scale_rsp scale_rsp;

    logic [2:0]             r_state, n_state;
    logic [SAMPLE_BITS-1:0] r_burst_min, n_burst_min;
    logic [CW-1:0]          r_range_low, n_range_low;
    logic [CW-1:0]          r_range_high, n_range_high;
    logic [SAMPLE_BITS-1:0] r_m, n_m;
    logic                   r_neg, n_neg;
    logic [QW-1:0]          r_mag, n_mag;
    logic [QW-1:0]          r_add, n_add;
    logic signed [7:0]      r_val, n_val;
    logic [2:0]             r_dir, n_dir;
    logic                   r_fail, n_fail;
    logic                   r_out_valid, n_out_valid;
    jacs_pkg::t_out_beat    r_out, n_out;

    jacs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    jacs_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scale_req),
        .o_rsp   (scale_rsp)
    );

    logic                   in_acc;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] m_new;
    logic [CW-1:0]          m16;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign raw         = i_in_beat.raw_count[SAMPLE_BITS-1:0];
    assign m_new       = (raw < r_burst_min) ? raw : r_burst_min;
    assign m16         = CW'(m_new);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // range mapping of the burst minimum
    logic signed [MW-1:0] rr, play, half, base, top, center;
    logic signed [MW-1:0] s_lo, s_clo, s_chi, s_hi, p_lo, p_hi;
    logic signed [MW-1:0] map_dx, map_dd;
    logic                 map_scale, map_neg;
    logic [QW-1:0]        map_mag;

    assign rr     = $signed(MW'(r_m));
    assign play   = $signed(MW'(cfg.dead_play));
    assign half   = play >>> 1;
    assign base   = $signed(MW'(cfg.range_base));
    assign top    = $signed(MW'(cfg.range_top));
    assign center = $signed(MW'(cfg.center_point));
    assign s_lo   = base + half;
    assign s_clo  = center - play;
    assign s_chi  = center + play;
    assign s_hi   = top - half;
    assign p_lo   = (cfg.axis_mode == jacs_pkg::MODE_HAT) ? base : base + play;
    assign p_hi   = (cfg.axis_mode == jacs_pkg::MODE_HAT) ? top : top - play;

    always_comb begin
        map_scale = 1'b0;
        map_neg   = 1'b0;
        map_mag   = '0;
        map_dx    = '0;
        map_dd    = '0;
        if (cfg.axis_mode == jacs_pkg::MODE_SYM) begin
            priority if (rr < s_lo) begin
                map_mag = jacs_pkg::FULL_SCALE;
                map_neg = 1'b1;
            end else if (rr < s_clo) begin
                map_scale = 1'b1;
                map_dx    = s_clo - rr;
                map_dd    = s_clo - s_lo;
                map_neg   = 1'b1;
            end else if (rr < s_chi) begin
                map_mag = '0;
            end else if (rr < s_hi) begin
                map_scale = 1'b1;
                map_dx    = rr - s_chi;
                map_dd    = s_hi - s_chi;
            end else begin
                map_mag = jacs_pkg::FULL_SCALE;
            end
        end else begin
            priority if (rr <= p_lo) begin
                map_mag = '0;
            end else if (rr >= p_hi) begin
                map_mag = jacs_pkg::FULL_SCALE;
            end else begin
                map_scale = 1'b1;
                map_dx    = rr - p_lo;
                map_dd    = p_hi - p_lo;
            end
        end
    end

    // post-processing of the magnitude
    logic [QW-1:0]        pos;
    logic signed [7:0]    mag_s;
    logic [7:0]           hat_sum;
    logic [2:0]           hat_dir;
    logic signed [TW-1:0] p_s, t_lo, t_hi;
    logic                 c_full;

    assign pos     = cfg.invert_axis ? jacs_pkg::FULL_SCALE - r_mag : r_mag;
    assign mag_s   = $signed(8'(r_mag));
    assign hat_sum = 8'(r_mag) + HAT_BIAS;
    assign p_s     = $signed(TW'(pos));
    assign t_lo    = $signed(TW'(cfg.center_point)) - $signed(TW'(cfg.detent_idle));
    assign t_hi    = $signed(TW'(cfg.center_point)) + $signed(TW'(cfg.detent_idle));
    assign c_full  = cfg.center_point >= CW'(jacs_pkg::FULL_SCALE);

    always_comb begin
        priority if (hat_sum >= HAT_Q4) hat_dir = 3'd4;
        else if (hat_sum >= HAT_Q3)     hat_dir = 3'd3;
        else if (hat_sum >= HAT_Q2)     hat_dir = 3'd2;
        else if (hat_sum >= HAT_Q1)     hat_dir = 3'd1;
        else                            hat_dir = 3'd0;
    end

    always_comb begin
        n_state      = r_state;
        n_burst_min  = r_burst_min;
        n_range_low  = r_range_low;
        n_range_high = r_range_high;
        n_m          = r_m;
        n_neg        = r_neg;
        n_mag        = r_mag;
        n_add        = r_add;
        n_val        = r_val;
        n_dir        = r_dir;
        n_fail       = r_fail;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        scale_req    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_beat.operation == jacs_pkg::OP_CLEAR) begin
                        n_range_low  = jacs_pkg::TRACK_LOW_RESET;
                        n_range_high = jacs_pkg::TRACK_HIGH_RESET;
                    end else if (!i_in_beat.last_of_burst) begin
                        n_burst_min = m_new;
                    end else begin
                        n_burst_min = SAMPLE_MAX;
                        n_m         = m_new;
                        n_dir       = jacs_pkg::HAT_CENTER;
                        if (i_in_beat.timed_out) begin
                            n_fail  = 1'b1;
                            n_val   = '0;
                            n_state = S_EMIT;
                        end else begin
                            n_fail = 1'b0;
                            if (m16 < r_range_low) begin
                                n_range_low = m16;
                            end
                            if (m16 > r_range_high) begin
                                n_range_high = m16;
                            end
                            n_state = S_MAP;
                        end
                    end
                end
            end
            S_MAP: begin
                n_neg = map_neg ^ cfg.invert_axis;
                if (map_scale) begin
                    scale_req.start = 1'b1;
                    scale_req.x     = map_dx[CW-1:0];
                    scale_req.den   = map_dd[CW-1:0];
                    scale_req.k     = jacs_pkg::FULL_SCALE;
                    n_state         = S_WAIT1;
                end else begin
                    n_mag   = map_mag;
                    n_state = S_POST;
                end
            end
            S_WAIT1: begin
                if (scale_rsp.done) begin
                    n_mag   = scale_rsp.quot;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                n_state = S_EMIT;
                unique case (cfg.axis_mode)
                    jacs_pkg::MODE_SYM: n_val = r_neg ? -mag_s : mag_s;
                    jacs_pkg::MODE_POS: n_val = $signed(8'(pos));
                    jacs_pkg::MODE_HAT: begin
                        n_val = mag_s;
                        n_dir = hat_dir;
                    end
                    jacs_pkg::MODE_THR: begin
                        priority if (p_s < t_lo) begin
                            scale_req.start = 1'b1;
                            scale_req.x     = CW'(pos);
                            scale_req.den   = cfg.center_point;
                            scale_req.k     = jacs_pkg::DETENT_POS;
                            n_add           = '0;
                            n_state         = S_WAIT2;
                        end else if (p_s < t_hi) begin
                            n_val = $signed(8'(jacs_pkg::DETENT_POS));
                        end else if (c_full) begin
                            n_val = $signed(8'(jacs_pkg::FULL_SCALE));
                        end else begin
                            scale_req.start = 1'b1;
                            scale_req.x     = CW'(pos - cfg.center_point[QW-1:0]);
                            scale_req.den   = CW'(jacs_pkg::FULL_SCALE
                                                  - cfg.center_point[QW-1:0]);
                            scale_req.k     = jacs_pkg::DETENT_SPAN;
                            n_add           = jacs_pkg::DETENT_POS;
                            n_state         = S_WAIT2;
                        end
                    end
                endcase
            end
            S_WAIT2: begin
                if (scale_rsp.done) begin
                    n_val   = $signed(8'(r_add + scale_rsp.quot));
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.axis_value    = r_val;
                    n_out.hat_direction = r_dir;
                    n_out.read_failed   = r_fail;
                    n_out.burst_minimum = r_fail ? '0 : CW'(r_m);
                    n_out.tracked_low   = r_range_low;
                    n_out.tracked_high  = r_range_high;
                    n_state             = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_burst_min  <= SAMPLE_MAX;
            r_range_low  <= jacs_pkg::TRACK_LOW_RESET;
            r_range_high <= jacs_pkg::TRACK_HIGH_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_burst_min  <= n_burst_min;
            r_range_low  <= n_range_low;
            r_range_high <= n_range_high;
            r_out_valid  <= n_out_valid;
            r_m          <= n_m;
            r_neg        <= n_neg;
            r_mag        <= n_mag;
            r_add        <= n_add;
            r_val        <= n_val;
            r_dir        <= n_dir;
            r_fail       <= n_fail;
            r_out        <= n_out;
        end
    end

    `JACS_ASSERT_IMP(a_fail_fields, i_clk, i_rst_n, o_out_valid && o_out_beat.read_failed, (o_out_beat.axis_value == 8'sd0) && (o_out_beat.hat_direction == jacs_pkg::HAT_CENTER) && (o_out_beat.burst_minimum == '0))
    `JACS_ASSERT_IMP(a_value_range, i_clk, i_rst_n, o_out_valid, (o_out_beat.axis_value >= -8'sd100) && (o_out_beat.axis_value <= 8'sd100))
    `JACS_ASSERT_IMP(a_trackers_span, i_clk, i_rst_n, o_out_valid && !o_out_beat.read_failed, (o_out_beat.tracked_low <= o_out_beat.burst_minimum) && (o_out_beat.tracked_high >= o_out_beat.burst_minimum))
    `JACS_ASSERT_NXT(a_burst_restart, i_clk, i_rst_n, in_acc && (i_in_beat.operation == jacs_pkg::OP_SAMPLE) && i_in_beat.last_of_burst, r_burst_min == SAMPLE_MAX)

endmodule

[dv/joystick_axis_calibrated_scaler_tb.sv]
module joystick_axis_calibrated_scaler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jacs_pkg::*;

    localparam int     DRAIN_CYCLES = 60;
    localparam int     STALL_LIMIT  = 4000;
    localparam int     PHASE_ITEMS  = 105;
    localparam longint SCALE        = FULL_SCALE;
    localparam longint DETENT       = DETENT_POS;
    localparam logic [CALC_W-1:0] BURST_MIN_RESET = 16'hffff;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CALC_W-1:0]    data;
    } t_reg_write;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in_beat   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out_beat;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CALC_W-1:0]     i_cfg_data  = '0;

    // predictor state
    t_cfg              axis_cfg;
    logic [CALC_W-1:0] burst_low;
    logic [CALC_W-1:0] track_lo;
    logic [CALC_W-1:0] track_hi;

    t_in_beat   sample_feed[$];
    t_out_beat  pending_readings[$];
    t_reg_write cfg_writes[$];

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int in_gap       = 0;
    int rx_stall     = 0;
    int rx_hold      = 0;
    int readings_seen = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    joystick_axis_calibrated_scaler uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint scaled(longint a, longint b, longint c);
        return (c == 0) ? 0 : (a * b) / c;
    endfunction

    function automatic longint sym_value(longint r);
        longint play, lo, c_lo, c_hi, hi, v;
        play = longint'(axis_cfg.dead_play);
        lo   = longint'(axis_cfg.range_base) + (play >>> 1);
        c_lo = longint'(axis_cfg.center_point) - play;
        c_hi = longint'(axis_cfg.center_point) + play;
        hi   = longint'(axis_cfg.range_top) - (play >>> 1);
        if (r < lo) v = -SCALE;
        else if (r < c_lo) v = -scaled(SCALE, c_lo - r, c_lo - lo);
        else if (r < c_hi) v = 0;
        else if (r < hi) v = scaled(SCALE, r - c_hi, hi - c_hi);
        else v = SCALE;
        return axis_cfg.invert_axis ? -v : v;
    endfunction

    function automatic longint pos_value(longint r);
        longint play, lo, hi, v;
        play = longint'(axis_cfg.dead_play);
        lo   = longint'(axis_cfg.range_base) + play;
        hi   = longint'(axis_cfg.range_top) - play;
        if (r <= lo) v = 0;
        else if (r >= hi) v = SCALE;
        else v = scaled(SCALE, r - lo, hi - lo);
        return axis_cfg.invert_axis ? SCALE - v : v;
    endfunction

    function automatic longint thr_value(longint r);
        longint p, c, idle;
        p    = pos_value(r);
        c    = longint'(axis_cfg.center_point);
        idle = longint'(axis_cfg.detent_idle);
        if (p < c - idle) return scaled(p, DETENT, c);
        if (p < c + idle) return DETENT;
        if (c >= SCALE) return SCALE;
        return DETENT + scaled(SCALE - DETENT, p - c, SCALE - c);
    endfunction

    function automatic longint hat_value(longint r);
        longint base, top;
        base = longint'(axis_cfg.range_base);
        top  = longint'(axis_cfg.range_top);
        if (r <= base) return 0;
        if (r >= top) return SCALE;
        return scaled(SCALE, r - base, top - base);
    endfunction

    // advances the axis state by one accepted beat; returns 1 when a reading is due
    function automatic bit predict_reading(input t_in_beat b, output t_out_beat r);
        logic [CALC_W-1:0] m;
        longint            v;
        logic [2:0]        dir;
        r = '0;
        if (b.operation == OP_CLEAR) begin
            track_lo = TRACK_LOW_RESET;
            track_hi = TRACK_HIGH_RESET;
            return 1'b0;
        end
        if (b.raw_count < burst_low) burst_low = b.raw_count;
        if (!b.last_of_burst) return 1'b0;
        m = burst_low;
        burst_low = BURST_MIN_RESET;
        r.tracked_low  = track_lo;
        r.tracked_high = track_hi;
        r.hat_direction = HAT_CENTER;
        if (b.timed_out) begin
            r.read_failed = 1'b1;
            return 1'b1;
        end
        if (m < track_lo) track_lo = m;
        if (m > track_hi) track_hi = m;
        dir = HAT_CENTER;
        case (axis_cfg.axis_mode)
            MODE_SYM: v = sym_value(longint'(m));
            MODE_POS: v = pos_value(longint'(m));
            MODE_THR: v = thr_value(longint'(m));
            default: begin
                v   = hat_value(longint'(m));
                dir = 3'((v + SCALE / 8) / (SCALE / 4));
            end
        endcase
        r.axis_value    = 8'(v);
        r.hat_direction = dir;
        r.burst_minimum = m;
        r.tracked_low   = track_lo;
        r.tracked_high  = track_hi;
        return 1'b1;
    endfunction

    function automatic int idle_length(bit enabled);
        int unsigned pick;
        if (!enabled) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    function automatic t_in_beat make_beat(logic op, logic [CALC_W-1:0] raw, logic tmo,
                                           logic last);
        t_in_beat b;
        b.operation     = op;
        b.raw_count     = raw;
        b.timed_out     = tmo;
        b.last_of_burst = last;
        return b;
    endfunction

    // burst minimum aimed at the mapping breakpoints of the current setting
    function automatic longint pick_level();
        longint base, top, mid, play, jit, v;
        base = longint'(axis_cfg.range_base);
        top  = longint'(axis_cfg.range_top);
        mid  = longint'(axis_cfg.center_point);
        play = longint'(axis_cfg.dead_play);
        jit  = longint'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 14))
            0: v = 0;
            1: v = 65535;
            2: v = base + jit;
            3: v = base + (play >>> 1) + jit;
            4: v = base + play + jit;
            5: v = top + jit;
            6: v = top - (play >>> 1) + jit;
            7: v = top - play + jit;
            8: v = mid - play + jit;
            9: v = mid + play + jit;
            10, 11, 12: begin
                if (base < top) v = base + $urandom_range(0, top - base);
                else v = top + $urandom_range(0, base - top);
            end
            default: v = $urandom_range(0, 65535);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v;
    endfunction

    function automatic int add_burst(logic fail_end);
        int     len, at;
        longint lvl, raw;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 3);
        at  = $urandom_range(0, len - 1);
        lvl = pick_level();
        for (int i = 0; i < len; i++) begin
            if (i == at) raw = lvl;
            else if ($urandom_range(0, 1)) raw = lvl + $urandom_range(0, 40);
            else raw = lvl + $urandom_range(0, 65535 - lvl);
            if (raw > 65535) raw = 65535;
            sample_feed.push_back(make_beat(OP_SAMPLE, 16'(raw),
                (i == len - 1) ? fail_end : ($urandom_range(0, 3) == 0), i == len - 1));
        end
        return len;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // waits until nothing is in flight, then lets the block drain
    task automatic settle();
        while (sample_feed.size() != 0 || i_in_valid || pending_readings.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic configure(logic [1:0] mode, logic [CALC_W-1:0] base, top, center, play,
                             logic inv, logic [6:0] idle);
        settle();
        cfg_writes.push_back('{CFG_AXIS_MODE,    CALC_W'(mode)});
        cfg_writes.push_back('{CFG_RANGE_BASE,   base});
        cfg_writes.push_back('{CFG_RANGE_TOP,    top});
        cfg_writes.push_back('{CFG_CENTER_POINT, center});
        cfg_writes.push_back('{CFG_DEAD_PLAY,    play});
        cfg_writes.push_back('{CFG_INVERT_AXIS,  CALC_W'(inv)});
        cfg_writes.push_back('{CFG_DETENT_IDLE,  CALC_W'(idle)});
        while (cfg_writes.size() != 0 || i_cfg_valid) @(negedge i_clk);
    endtask

    task automatic run_random(int n);
        int          queued;
        int unsigned pick;
        queued = 0;
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
        while (queued < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 86) begin
                queued += add_burst(1'b0);
            end else if (pick < 93) begin
                queued += add_burst(1'b1);
            end else if (pick < 96) begin
                sample_feed.push_back(make_beat(OP_CLEAR, 16'($urandom), 1'($urandom),
                                                1'($urandom)));
                queued++;
            end else begin
                sample_feed.push_back(make_beat(OP_SAMPLE, 16'($urandom), 1'($urandom),
                                                1'($urandom)));
                queued++;
            end
        end
    endtask

    always @(posedge i_clk) begin : feed_driver
        t_out_beat due;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (predict_reading(i_in_beat, due)) pending_readings.push_back(due);
                in_gap = idle_length(tx_idle_on);
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (sample_feed.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_in_beat  <= sample_feed.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : reading_monitor
        t_out_beat want;
        bit        rdy;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                readings_seen++;
                if (pending_readings.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected beat, expected none, actual %p", $time,
                             o_out_beat);
                end else begin
                    want = pending_readings.pop_front();
                    check_field("axis_value", want.axis_value, o_out_beat.axis_value);
                    check_field("hat_direction", want.hat_direction,
                                o_out_beat.hat_direction);
                    check_field("read_failed", want.read_failed, o_out_beat.read_failed);
                    check_field("burst_minimum", want.burst_minimum,
                                o_out_beat.burst_minimum);
                    check_field("tracked_low", want.tracked_low, o_out_beat.tracked_low);
                    check_field("tracked_high", want.tracked_high, o_out_beat.tracked_high);
                end
                // long back-pressure so the block fills and stalls its input
                if (readings_seen % 250 == 100) rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rdy = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                rdy = 1'b0;
            end else begin
                rx_stall = idle_length(rx_idle_on);
                rdy = (rx_stall == 0);
                if (rx_stall > 0) rx_stall--;
            end
            i_out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin : reg_driver
        t_reg_write w;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AXIS_MODE:    axis_cfg.axis_mode    = i_cfg_data[1:0];
                    CFG_RANGE_BASE:   axis_cfg.range_base   = i_cfg_data;
                    CFG_RANGE_TOP:    axis_cfg.range_top    = i_cfg_data;
                    CFG_CENTER_POINT: axis_cfg.center_point = i_cfg_data;
                    CFG_DEAD_PLAY:    axis_cfg.dead_play    = i_cfg_data;
                    CFG_INVERT_AXIS:  axis_cfg.invert_axis  = i_cfg_data[0];
                    CFG_DETENT_IDLE:  axis_cfg.detent_idle  = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (cfg_writes.size() != 0) begin
                    w = cfg_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= w.index;
                    i_cfg_data  <= w.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("joystick_axis_calibrated_scaler verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        axis_cfg  = '{RST_AXIS_MODE, RST_RANGE_BASE, RST_RANGE_TOP, RST_CENTER_POINT,
                      RST_DEAD_PLAY, RST_INVERT_AXIS, RST_DETENT_IDLE};
        burst_low = BURST_MIN_RESET;
        track_lo  = TRACK_LOW_RESET;
        track_hi  = TRACK_HIGH_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: full-scale symmetric
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd0,     1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'hffff,  1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd32768, 1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd500,   1'b1, 1'b0));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd200,   1'b0, 1'b0));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd900,   1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd100,   1'b0, 1'b0));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd50,    1'b1, 1'b1));
        sample_feed.push_back(make_beat(OP_CLEAR,  16'hffff,  1'b1, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd40000, 1'b0, 1'b1));

        configure(MODE_HAT, 16'd1000, 16'd5000, 16'd32768, 16'd0, 1'b0, 7'd10);
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd999,  1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd1500, 1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd3000, 1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd4499, 1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd5000, 1'b0, 1'b1));

        // detent at full scale: upper branch pins to 100
        configure(MODE_THR, 16'd0, 16'd1000, 16'd100, 16'd0, 1'b0, 7'd0);
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd0,    1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd500,  1'b0, 1'b1));
        sample_feed.push_back(make_beat(OP_SAMPLE, 16'd1000, 1'b0, 1'b1));

        configure(MODE_SYM, 16'd1000, 16'd60000, 16'd30000, 16'd500, 1'b0, 7'd10);
        run_random(PHASE_ITEMS);
        configure(MODE_SYM, 16'd1000, 16'd60000, 16'd30000, 16'd500, 1'b1, 7'd10);
        run_random(PHASE_ITEMS);
        configure(MODE_SYM, 16'd0, 16'hffff, 16'hffff, 16'hffff, 1'b1, 7'd0);
        run_random(PHASE_ITEMS);
        configure(MODE_SYM, 16'd30000, 16'd30000, 16'd30000, 16'd0, 1'b0, 7'd100);
        run_random(PHASE_ITEMS);
        configure(MODE_POS, 16'd2000, 16'd50000, 16'd0, 16'd100, 1'b0, 7'd0);
        run_random(PHASE_ITEMS);
        configure(MODE_POS, 16'd2000, 16'd50000, 16'd0, 16'd100, 1'b1, 7'd0);
        run_random(PHASE_ITEMS);
        configure(MODE_POS, 16'd60000, 16'd100, 16'd0, 16'd0, 1'b0, 7'd0);
        run_random(PHASE_ITEMS);
        configure(MODE_THR, 16'd0, 16'hffff, 16'd50, 16'd0, 1'b0, 7'd10);
        run_random(PHASE_ITEMS);
        configure(MODE_THR, 16'd3000, 16'd40000, 16'd100, 16'd200, 1'b1, 7'd5);
        run_random(PHASE_ITEMS);
        configure(MODE_THR, 16'd500, 16'd20000, 16'd0, 16'd0, 1'b0, 7'd100);
        run_random(PHASE_ITEMS);
        configure(MODE_THR, 16'd0, 16'hffff, 16'hffff, 16'hffff, 1'b1, 7'd100);
        run_random(PHASE_ITEMS);
        configure(MODE_HAT, 16'd1000, 16'd5000, 16'd0, 16'd0, 1'b0, 7'd0);
        run_random(PHASE_ITEMS);
        configure(MODE_HAT, 16'd0, 16'hffff, 16'd32768, 16'd300, 1'b1, 7'd50);
        run_random(PHASE_ITEMS);
        configure(MODE_HAT, 16'd9000, 16'd9000, 16'd9000, 16'd0, 1'b0, 7'd10);
        run_random(PHASE_ITEMS);
        repeat (3) begin
            configure(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                      ($urandom_range(0, 1) ? 16'($urandom_range(0, 120)) : 16'($urandom)),
                      16'($urandom_range(0, 3000)), 1'($urandom),
                      7'($urandom_range(0, 100)));
            run_random(PHASE_ITEMS);
        end

        settle();
        if (mismatches == 0) begin
            $display("joystick_axis_calibrated_scaler verification clean");
        end else begin
            $display("joystick_axis_calibrated_scaler verification failed");
        end
        $finish;
    end

endmodule
